@@ design/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, off while in reset
`define MRRP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check that some condition never shows up
`define MRRP_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

@@ design/mrrp_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package mrrp_pkg;

  localparam int MAX_VALUES = 64;
  localparam int IDX_W      = $clog2(MAX_VALUES);
  localparam int CNT_W      = 7;
  localparam int POS_W      = 9;
  localparam int CFG_IDX_W  = 2;

  localparam logic [POS_W-1:0] POS_MAX  = 9'd511;
  localparam logic [15:0]      CRC_SEED = 16'hFFFF;
  localparam logic [15:0]      CRC_POLY = 16'hA001;
  localparam logic [3:0]       CRC_BITS = 4'd8;

  localparam logic [CFG_IDX_W-1:0] CFG_STATION  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FUNCTION = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_REGS = 2'd2;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_SHORT      = 3'd1,
    ST_MISMATCH   = 3'd2,
    ST_BAD_COUNT  = 3'd3,
    ST_INCOMPLETE = 3'd4,
    ST_CRC        = 3'd5
  } status_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_end;
  } in_t;

  typedef struct packed {
    status_t            status;
    logic [5:0]         reg_index;
    logic signed [15:0] reg_value;
    logic [6:0]         reg_count;
    logic               last;
  } out_t;

  typedef struct packed {
    logic       clear;
    logic       start;
    logic [7:0] data;
  } crc_ctrl_t;

endpackage

`default_nettype wire

@@ design/mrrp_crc_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module mrrp_crc_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  mrrp_pkg::crc_ctrl_t ctrl,
  output logic               busy,
  output logic [15:0]        crc
);
  import mrrp_pkg::*;

  logic [15:0] crc_r, crc_nxt;
  logic [3:0]  cnt_r, cnt_nxt;

  always_comb begin
    crc_nxt = crc_r;
    cnt_nxt = cnt_r;
    if (ctrl.clear) begin
      crc_nxt = CRC_SEED;
    end else if (ctrl.start) begin
      crc_nxt = crc_r ^ {8'h00, ctrl.data};
      cnt_nxt = CRC_BITS;
    end else if (cnt_r != 4'd0) begin
      // one reflected shift per cycle
      crc_nxt = crc_r[0] ? ((crc_r >> 1) ^ CRC_POLY) : (crc_r >> 1);
      cnt_nxt = cnt_r - 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r <= CRC_SEED;
      cnt_r <= 4'd0;
    end else begin
      crc_r <= crc_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  assign busy = (cnt_r != 4'd0);
  assign crc  = crc_r;

  `MRRP_NEVER(a_start_while_busy, ctrl.start && busy, "crc byte started while shifting")
  `MRRP_ASSERT(a_start_loads, ctrl.start && !ctrl.clear |=> cnt_r == CRC_BITS, "crc count not loaded")

endmodule

`default_nettype wire

@@ design/mrrp_value_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module mrrp_value_ram (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [mrrp_pkg::IDX_W-1:0] wr_addr,
  input  logic [15:0]                wr_data,
  input  logic                       rd_en,
  input  logic [mrrp_pkg::IDX_W-1:0] rd_addr,
  output logic [15:0]                rd_data
);
  import mrrp_pkg::*;

  logic [15:0] mem [MAX_VALUES];
  logic [15:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

@@ design/modbus_read_response_parser.sv @@
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

// Modbus RTU read-holding-registers response parser. Frame bytes enter one per
// transaction on in_*, with frame_end set on the last byte of a frame. Each byte
// of address, function, byte count and data passes through a bit-serial CRC16
// unit, so such a byte holds the input while the unit shifts it (accept, shift,
// hand-back); bytes outside the CRC span do not wait. At frame end the checks
// run, then each register value leaves on out_* (value store read, then output
// load, held while out_* stalls), or one error transaction is sent with status
// set and zero count, index and value. The output register lets the next frame's
// bytes come in while the last result waits. Configuration writes on cfg_* are
// always taken and are meant for times when no frame is underway.
module modbus_read_response_parser (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  mrrp_pkg::in_t                       in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output mrrp_pkg::out_t                      out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [mrrp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [7:0]                          cfg_data
);
  import mrrp_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_CRC   = 6'b000010,
    S_CHECK = 6'b000100,
    S_ERR   = 6'b001000,
    S_RD    = 6'b010000,
    S_WR    = 6'b100000
  } state_t;

  localparam logic [7:0]       MAX_VAL8 = 8'(MAX_VALUES);
  localparam logic [CNT_W-1:0] MAX_VALC = CNT_W'(MAX_VALUES);

  state_t           state_r, state_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [7:0]       first_r, first_nxt;
  logic [7:0]       second_r, second_nxt;
  logic [7:0]       bc_r, bc_nxt;
  logic [15:0]      rcrc_r, rcrc_nxt;
  logic [7:0]       pend_r, pend_nxt;
  logic             end_r, end_nxt;
  logic [7:0]       station_r, station_nxt;
  logic [7:0]       func_r, func_nxt;
  logic [6:0]       maxreg_r, maxreg_nxt;
  status_t          status_r, status_nxt;
  logic [CNT_W-1:0] n_r, n_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_t             out_data_r, out_data_nxt;

  crc_ctrl_t        crc_ctrl;
  logic             crc_busy;
  logic [15:0]      crc_val;

  logic             ram_wr_en, ram_rd_en;
  logic [IDX_W-1:0] ram_wr_addr;
  logic [15:0]      ram_wr_data, ram_rd_data;

  logic             in_acc, out_free;
  logic [POS_W-1:0] bc_plus3, off;
  logic [7:0]       ri;
  logic             crc_en, is_last;
  logic [CNT_W-1:0] half, lim;

  mrrp_crc_unit u_crc (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (crc_ctrl),
    .busy  (crc_busy),
    .crc   (crc_val)
  );

  mrrp_value_ram u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (idx_r),
    .rd_data (ram_rd_data)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign cfg_ready = 1'b1;

  assign bc_plus3 = {1'b0, bc_r} + 9'd3;
  assign crc_en   = (pos_r < bc_plus3);
  assign off      = pos_r - 9'd3;
  assign ri       = off[8:1];
  assign is_last  = (CNT_W'(idx_r) + CNT_W'(1)) == n_r;
  assign half     = CNT_W'(bc_r[7:1]);
  assign lim      = (half < maxreg_r) ? half : maxreg_r;

  always_comb begin
    state_nxt     = state_r;
    pos_nxt       = pos_r;
    first_nxt     = first_r;
    second_nxt    = second_r;
    bc_nxt        = bc_r;
    rcrc_nxt      = rcrc_r;
    pend_nxt      = pend_r;
    end_nxt       = end_r;
    status_nxt    = status_r;
    n_nxt         = n_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    crc_ctrl      = '0;
    crc_ctrl.data = in_data.rx_byte;
    ram_wr_en     = 1'b0;
    ram_wr_addr   = ri[IDX_W-1:0];
    ram_wr_data   = {pend_r, in_data.rx_byte};
    ram_rd_en     = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          end_nxt = in_data.frame_end;
          if (crc_en) begin
            crc_ctrl.start = 1'b1;
            if (pos_r == 9'd0) begin
              first_nxt = in_data.rx_byte;
            end else if (pos_r == 9'd1) begin
              second_nxt = in_data.rx_byte;
            end else if (pos_r == 9'd2) begin
              bc_nxt = in_data.rx_byte;
            end else if (!off[0]) begin
              pend_nxt = in_data.rx_byte;
            end else begin
              ram_wr_en = (ri < MAX_VAL8);
            end
          end else if (pos_r == bc_plus3) begin
            rcrc_nxt = {rcrc_r[15:8], in_data.rx_byte};
          end else if (pos_r == bc_plus3 + 9'd1) begin
            rcrc_nxt = {in_data.rx_byte, rcrc_r[7:0]};
          end
          if (pos_r != POS_MAX) begin
            pos_nxt = pos_r + 9'd1;
          end
          if (crc_en) begin
            state_nxt = S_CRC;
          end else if (in_data.frame_end) begin
            state_nxt = S_CHECK;
          end
        end
      end
      S_CRC: begin
        if (!crc_busy) begin
          state_nxt = end_r ? S_CHECK : S_IDLE;
        end
      end
      S_CHECK: begin
        // checks in priority order, first failure wins
        if (pos_r < 9'd5 || maxreg_r == 7'd0) begin
          status_nxt = ST_SHORT;
        end else if (first_r != station_r || second_r != func_r) begin
          status_nxt = ST_MISMATCH;
        end else if (bc_r == 8'd0 || bc_r[0]) begin
          status_nxt = ST_BAD_COUNT;
        end else if (pos_r < {1'b0, bc_r} + 9'd5) begin
          status_nxt = ST_INCOMPLETE;
        end else if (crc_val != rcrc_r) begin
          status_nxt = ST_CRC;
        end else begin
          status_nxt = ST_OK;
        end
        n_nxt     = (lim < MAX_VALC) ? lim : MAX_VALC;
        idx_nxt   = '0;
        state_nxt = (status_nxt == ST_OK) ? S_RD : S_ERR;
      end
      S_ERR: begin
        if (out_free) begin
          out_valid_nxt          = 1'b1;
          out_data_nxt.status    = status_r;
          out_data_nxt.reg_index = '0;
          out_data_nxt.reg_value = '0;
          out_data_nxt.reg_count = '0;
          out_data_nxt.last      = 1'b1;
          state_nxt              = S_IDLE;
        end
      end
      S_RD: begin
        ram_rd_en = 1'b1;
        state_nxt = S_WR;
      end
      S_WR: begin
        if (out_free) begin
          out_valid_nxt          = 1'b1;
          out_data_nxt.status    = ST_OK;
          out_data_nxt.reg_index = 6'(idx_r);
          out_data_nxt.reg_value = ram_rd_data;
          out_data_nxt.reg_count = n_r;
          out_data_nxt.last      = is_last;
          if (is_last) begin
            state_nxt = S_IDLE;
          end else begin
            idx_nxt   = idx_r + IDX_W'(1);
            state_nxt = S_RD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // frame state back to its start values once the frame is answered
    if ((state_r == S_ERR || (state_r == S_WR && is_last)) && out_free) begin
      pos_nxt        = '0;
      first_nxt      = '0;
      second_nxt     = '0;
      bc_nxt         = '0;
      rcrc_nxt       = '0;
      pend_nxt       = '0;
      end_nxt        = 1'b0;
      crc_ctrl.clear = 1'b1;
    end
  end

  always_comb begin
    station_nxt = station_r;
    func_nxt    = func_r;
    maxreg_nxt  = maxreg_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_STATION:  station_nxt = cfg_data;
        CFG_FUNCTION: func_nxt    = cfg_data;
        CFG_MAX_REGS: maxreg_nxt  = cfg_data[6:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pos_r       <= '0;
      first_r     <= '0;
      second_r    <= '0;
      bc_r        <= '0;
      rcrc_r      <= '0;
      pend_r      <= '0;
      end_r       <= 1'b0;
      station_r   <= 8'd10;
      func_r      <= 8'd3;
      maxreg_r    <= 7'd64;
      status_r    <= ST_OK;
      n_r         <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      first_r     <= first_nxt;
      second_r    <= second_nxt;
      bc_r        <= bc_nxt;
      rcrc_r      <= rcrc_nxt;
      pend_r      <= pend_nxt;
      end_r       <= end_nxt;
      station_r   <= station_nxt;
      func_r      <= func_nxt;
      maxreg_r    <= maxreg_nxt;
      status_r    <= status_nxt;
      n_r         <= n_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `MRRP_NEVER(a_ready_while_shifting, in_ready && crc_busy, "input taken while crc unit busy")
  `MRRP_ASSERT(a_error_shape,
    out_valid && out_data.status != ST_OK |-> out_data.reg_count == '0 && out_data.last,
    "error transaction not single and empty")
  `MRRP_ASSERT(a_idx_in_range,
    (state_r == S_RD || state_r == S_WR) |-> CNT_W'(idx_r) < n_r,
    "value index past delivered count")

endmodule

`default_nettype wire
